[design/kvaf_pkg.sv]
// Shared types, codes and helpers for the velocity/acceleration Kalman filter.
package kvaf_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_W  = 17;
	localparam int MAG_W  = 31;

	// operation codes carried by an input word
	localparam logic [1:0] OP_INIT    = 2'd0;
	localparam logic [1:0] OP_PREDICT = 2'd1;
	localparam logic [1:0] OP_UPDATE  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_STEP_TIME  = 2'd0;
	localparam logic [1:0] REG_Q_VELOCITY = 2'd1;
	localparam logic [1:0] REG_Q_ACCEL    = 2'd2;
	localparam logic [1:0] REG_R_MEASURE  = 2'd3;

	// datapath jobs; each runs four phases on the shared multiplier
	typedef enum logic [3:0] {
		JOB_INIT,
		JOB_FP,
		JOB_FPF,
		JOB_XP,
		JOB_S,
		JOB_DET,
		JOB_NUM,
		JOB_Y,
		JOB_XU,
		JOB_PU,
		JOB_COPY,
		JOB_SQ
	} job_t;

	typedef struct packed {
		logic       run;
		job_t       job;
		logic [3:0] idx;
		logic [1:0] phase;
		logic       load_in;
		logic       out_load;
		logic       div_start;
		logic       sqrt_start;
	} cmd_t;

	typedef struct packed {
		logic det_zero;
		logic div_done;
		logic sqrt_done;
	} sts_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			return $signed(32'h8000_0000);
		else
			return $signed(v[31:0]);
	endfunction

endpackage

[design/kvaf_if.sv]
// Valid/ready channel interfaces for input and result words.
interface kvaf_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] acc_x;
	logic signed [31:0] acc_y;

	modport source(output valid, op, vel_x, vel_y, acc_x, acc_y, input ready);
	modport sink(input valid, op, vel_x, vel_y, acc_x, acc_y, output ready);
endinterface

interface kvaf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] est_vx;
	logic signed [31:0] est_vy;
	logic signed [31:0] est_ax;
	logic signed [31:0] est_ay;
	logic [30:0]        accel_magnitude;

	modport source(output valid, est_vx, est_vy, est_ax, est_ay, accel_magnitude,
		input ready);
	modport sink(input valid, est_vx, est_vy, est_ax, est_ay, accel_magnitude,
		output ready);
endinterface

[design/kvaf_div.sv]
// Restoring divider for the Kalman gain, one quotient bit per cycle.
module kvaf_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] dvd_q, quo_q, dvd_init;
	logic [31:0]   rem_q, den_q, un, ud, mag;
	logic [32:0]   trial;
	logic          fit, big;

	assign un       = num[31] ? (~num + 32'd1) : num;
	assign ud       = den[31] ? (~den + 32'd1) : den;
	assign dvd_init = {un, {FRAC_BITS{1'b0}}} + NW'(ud[31:1]);
	assign trial    = {rem_q, dvd_q[NW-1]};
	assign fit      = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd_init;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= ud;
			neg_q <= num[31] ^ den[31];
		end else if (busy_q) begin
			rem_q <= fit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[NW-2:0], fit};
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
		end
	end

	// magnitude clamps at 2^31; positive side then clamps once more
	assign big  = (|quo_q[NW-1:32]) || (quo_q[31:0] > 32'h8000_0000);
	assign mag  = big ? 32'h8000_0000 : quo_q[31:0];
	assign quo  = neg_q ? $signed(~mag + 32'd1)
		: (mag[31] ? 32'sh7FFF_FFFF : $signed(mag));
	assign done = done_q;

endmodule

[design/kvaf_sqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
module kvaf_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] root
);
	logic        busy_q, done_q;
	logic [63:0] v_q, r_q, bit_q, sum;

	assign sum = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= rad;
			r_q   <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= sum) begin
				v_q <= v_q - sum;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

[design/kvaf_ctrl.sv]
// Sequencer: handshakes and the job/phase schedule for each operation.
module kvaf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_op,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output kvaf_pkg::cmd_t    cmd,
	input  kvaf_pkg::sts_t    sts
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_SQRT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t          state_q;
	kvaf_pkg::job_t  job_q;
	logic [3:0]      idx_q;
	logic [1:0]      phase_q;
	logic            out_valid_q;
	logic            run;

	assign run      = (state_q == ST_RUN);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.run        = run;
		cmd.job        = job_q;
		cmd.idx        = idx_q;
		cmd.phase      = phase_q;
		cmd.load_in    = in_valid && in_ready;
		cmd.out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		cmd.div_start  = run && (job_q == kvaf_pkg::JOB_NUM) && (phase_q == 2'd3);
		cmd.sqrt_start = run && (job_q == kvaf_pkg::JOB_SQ) && (phase_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= kvaf_pkg::JOB_SQ;
			idx_q       <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a fresh result takes precedence over the drain of the old one
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_RUN;
					idx_q   <= '0;
					phase_q <= '0;
					unique case (in_op)
						kvaf_pkg::OP_INIT:    job_q <= kvaf_pkg::JOB_INIT;
						kvaf_pkg::OP_PREDICT: job_q <= kvaf_pkg::JOB_FP;
						kvaf_pkg::OP_UPDATE:  job_q <= kvaf_pkg::JOB_S;
						default:              job_q <= kvaf_pkg::JOB_SQ;
					endcase
				end
				ST_RUN: begin
					if (job_q == kvaf_pkg::JOB_NUM && phase_q == 2'd0 && sts.det_zero) begin
						// singular innovation: leave state and P alone
						job_q <= kvaf_pkg::JOB_SQ;
						idx_q <= '0;
					end else if (phase_q != 2'd3) begin
						phase_q <= phase_q + 2'd1;
					end else begin
						phase_q <= '0;
						unique case (job_q)
							kvaf_pkg::JOB_INIT: job_q <= kvaf_pkg::JOB_SQ;
							kvaf_pkg::JOB_FP: if (idx_q == 4'd15) begin
								job_q <= kvaf_pkg::JOB_FPF;
								idx_q <= '0;
							end else idx_q <= idx_q + 4'd1;
							kvaf_pkg::JOB_FPF: if (idx_q == 4'd15) begin
								job_q <= kvaf_pkg::JOB_XP;
								idx_q <= '0;
							end else idx_q <= idx_q + 4'd1;
							kvaf_pkg::JOB_XP: if (idx_q == 4'd3) begin
								job_q <= kvaf_pkg::JOB_SQ;
								idx_q <= '0;
							end else idx_q <= idx_q + 4'd1;
							kvaf_pkg::JOB_S:   job_q <= kvaf_pkg::JOB_DET;
							kvaf_pkg::JOB_DET: begin
								job_q <= kvaf_pkg::JOB_NUM;
								idx_q <= '0;
							end
							kvaf_pkg::JOB_NUM: state_q <= ST_DIV;
							kvaf_pkg::JOB_Y: begin
								job_q <= kvaf_pkg::JOB_XU;
								idx_q <= '0;
							end
							kvaf_pkg::JOB_XU: if (idx_q == 4'd3) begin
								job_q <= kvaf_pkg::JOB_PU;
								idx_q <= '0;
							end else idx_q <= idx_q + 4'd1;
							kvaf_pkg::JOB_PU: if (idx_q == 4'd15) begin
								job_q <= kvaf_pkg::JOB_COPY;
								idx_q <= '0;
							end else idx_q <= idx_q + 4'd1;
							kvaf_pkg::JOB_COPY: job_q <= kvaf_pkg::JOB_SQ;
							kvaf_pkg::JOB_SQ:   state_q <= ST_SQRT;
							default:            state_q <= ST_SQRT;
						endcase
					end
				end
				ST_DIV: if (sts.div_done) begin
					state_q <= ST_RUN;
					if (idx_q == 4'd7) begin
						job_q <= kvaf_pkg::JOB_Y;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				ST_SQRT: if (sts.sqrt_done) state_q <= ST_DONE;
				ST_DONE: if (!out_valid_q || out_ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the gain step");

	a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sqrt_done |-> state_q == ST_SQRT)
		else $error("root finished outside the magnitude step");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result loaded but not presented");

	a_gain_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !idx_q[3])
		else $error("gain index out of range");

endmodule

[design/kvaf_dpath.sv]
// Datapath: state, covariance, shared multiplier/accumulator, divider and root.
module kvaf_dpath #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kvaf_pkg::cmd_t     cmd,
	output kvaf_pkg::sts_t     sts,
	input  logic               wr_en,
	input  logic [1:0]         wr_idx,
	input  logic [16:0]        wr_data,
	input  logic signed [31:0] in_vx,
	input  logic signed [31:0] in_vy,
	input  logic signed [31:0] in_ax,
	input  logic signed [31:0] in_ay,
	output logic signed [31:0] est_vx,
	output logic signed [31:0] est_vy,
	output logic signed [31:0] est_ax,
	output logic signed [31:0] est_ay,
	output logic [30:0]        accel_magnitude
);
	localparam longint ONE_L = longint'(1) << FRAC_BITS;
	localparam logic [63:0] STEP_RST = 64'((ONE_L * 5 + 50) / 100);
	localparam logic [63:0] QV_RST   = 64'((ONE_L + 50) / 100);
	localparam logic [63:0] QA_RST   = 64'((ONE_L * 10 + 50) / 100);
	localparam logic [63:0] RM_RST   = 64'((ONE_L * 10 + 50) / 100);
	localparam logic signed [31:0] ONE_W  = 32'(ONE_L);
	localparam logic signed [63:0] HALF_L = 64'(ONE_L >> 1);

	logic [16:0] step_q, qv_q, qa_q, rm_q;

	logic signed [31:0] x_q [4];
	logic signed [31:0] p_q [16];
	logic signed [31:0] t_q [16];
	logic signed [31:0] k_q [8];
	logic signed [31:0] z_q [4];
	logic signed [31:0] s00_q, s11_q, det_q, y0_q, y1_q;
	logic signed [63:0] mul_s1, acc_q;

	logic signed [31:0] a1, b1, a2, b2, base, a_mul, b_mul, m0, m1, res, wr_val, dt32;
	logic signed [63:0] rnd, term, qadd;
	logic               neg, raw;
	logic [1:0]         r_sel, c_sel, xi_p2;
	logic [3:0]         idx_p8, idx_p2;

	logic               div_done, sqrt_done;
	logic signed [31:0] div_quo;
	logic [31:0]        root;

	assign r_sel  = cmd.idx[3:2];
	assign c_sel  = cmd.idx[1:0];
	assign idx_p8 = cmd.idx + 4'd8;
	assign idx_p2 = cmd.idx + 4'd2;
	assign xi_p2  = c_sel + 2'd2;
	assign dt32   = $signed({15'd0, step_q});

	// row r of I - K H, columns 0 and 1
	assign m0 = kvaf_pkg::sat32(((r_sel == 2'd0) ? 64'(ONE_L) : 64'sd0)
		- 64'(k_q[{r_sel, 1'b0}]));
	assign m1 = kvaf_pkg::sat32(((r_sel == 2'd1) ? 64'(ONE_L) : 64'sd0)
		- 64'(k_q[{r_sel, 1'b1}]));

	always_comb begin
		a1 = '0; b1 = '0; a2 = '0; b2 = '0; base = '0; neg = 1'b0; raw = 1'b0;
		case (cmd.job)
			kvaf_pkg::JOB_FP: begin
				base = p_q[cmd.idx];
				if (!r_sel[1]) a1 = dt32;
				b1 = p_q[idx_p8];
			end
			kvaf_pkg::JOB_FPF: begin
				base = t_q[cmd.idx];
				if (!c_sel[1]) a1 = t_q[idx_p2];
				b1 = dt32;
			end
			kvaf_pkg::JOB_XP: begin
				base = x_q[c_sel];
				if (!c_sel[1]) a1 = dt32;
				b1 = x_q[xi_p2];
			end
			kvaf_pkg::JOB_DET: begin
				a1 = s00_q; b1 = s11_q;
				a2 = p_q[1]; b2 = p_q[4];
				neg = 1'b1;
			end
			kvaf_pkg::JOB_NUM: begin
				neg = 1'b1;
				if (!cmd.idx[0]) begin
					a1 = p_q[{cmd.idx[2:1], 2'b00}]; b1 = s11_q;
					a2 = p_q[{cmd.idx[2:1], 2'b01}]; b2 = p_q[4];
				end else begin
					a1 = p_q[{cmd.idx[2:1], 2'b01}]; b1 = s00_q;
					a2 = p_q[{cmd.idx[2:1], 2'b00}]; b2 = p_q[1];
				end
			end
			kvaf_pkg::JOB_XU: begin
				base = x_q[c_sel];
				a1 = k_q[{c_sel, 1'b0}]; b1 = y0_q;
				a2 = k_q[{c_sel, 1'b1}]; b2 = y1_q;
			end
			kvaf_pkg::JOB_PU: begin
				if (r_sel[1]) base = p_q[cmd.idx];
				a1 = m0; b1 = p_q[{2'b00, c_sel}];
				a2 = m1; b2 = p_q[{2'b01, c_sel}];
			end
			kvaf_pkg::JOB_SQ: begin
				a1 = x_q[2]; b1 = x_q[2];
				a2 = x_q[3]; b2 = x_q[3];
				raw = 1'b1;
			end
			default: ;
		endcase
	end

	assign a_mul = cmd.phase[0] ? a2 : a1;
	assign b_mul = cmd.phase[0] ? b2 : b1;
	assign rnd   = (mul_s1 + HALF_L) >>> FRAC_BITS;
	assign term  = raw ? mul_s1 : rnd;
	assign res   = kvaf_pkg::sat32(acc_q);

	// process noise lands on the diagonal after the second product
	always_comb begin
		qadd = '0;
		if (cmd.job == kvaf_pkg::JOB_FPF && c_sel == r_sel)
			qadd = $signed({47'd0, (r_sel[1] ? qa_q : qv_q)});
	end
	assign wr_val = kvaf_pkg::sat32(64'(res) + qadd);

	always_ff @(posedge clk) begin
		mul_s1 <= a_mul * b_mul;
		case (cmd.phase)
			2'd0:    acc_q <= 64'(base);
			2'd1:    acc_q <= acc_q + term;
			2'd2:    acc_q <= neg ? acc_q - term : acc_q + term;
			default: acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST[16:0];
			qv_q   <= QV_RST[16:0];
			qa_q   <= QA_RST[16:0];
			rm_q   <= RM_RST[16:0];
			for (int i = 0; i < 4; i++) x_q[i] <= '0;
			for (int i = 0; i < 16; i++) p_q[i] <= (i % 5 == 0) ? ONE_W : '0;
		end else begin
			if (wr_en) begin
				unique case (wr_idx)
					kvaf_pkg::REG_STEP_TIME:  step_q <= wr_data;
					kvaf_pkg::REG_Q_VELOCITY: qv_q   <= wr_data;
					kvaf_pkg::REG_Q_ACCEL:    qa_q   <= wr_data;
					kvaf_pkg::REG_R_MEASURE:  rm_q   <= wr_data;
					default: ;
				endcase
			end
			if (cmd.run && cmd.phase == 2'd3) begin
				case (cmd.job)
					kvaf_pkg::JOB_INIT: for (int i = 0; i < 4; i++) x_q[i] <= z_q[i];
					kvaf_pkg::JOB_FPF:  p_q[cmd.idx] <= wr_val;
					kvaf_pkg::JOB_XP:   x_q[c_sel] <= res;
					kvaf_pkg::JOB_XU:   x_q[c_sel] <= res;
					kvaf_pkg::JOB_COPY: for (int i = 0; i < 16; i++) p_q[i] <= t_q[i];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			z_q[0] <= in_vx;
			z_q[1] <= in_vy;
			z_q[2] <= in_ax;
			z_q[3] <= in_ay;
		end
		if (cmd.run && cmd.phase == 2'd3) begin
			case (cmd.job)
				kvaf_pkg::JOB_FP: t_q[cmd.idx] <= res;
				kvaf_pkg::JOB_PU: t_q[cmd.idx] <= res;
				kvaf_pkg::JOB_S: begin
					s00_q <= kvaf_pkg::sat32(64'(p_q[0]) + $signed({47'd0, rm_q}));
					s11_q <= kvaf_pkg::sat32(64'(p_q[5]) + $signed({47'd0, rm_q}));
				end
				kvaf_pkg::JOB_DET: det_q <= res;
				kvaf_pkg::JOB_Y: begin
					y0_q <= kvaf_pkg::sat32(64'(z_q[0]) - 64'(x_q[0]));
					y1_q <= kvaf_pkg::sat32(64'(z_q[1]) - 64'(x_q[1]));
				end
				default: ;
			endcase
		end
		if (div_done)
			k_q[cmd.idx[2:0]] <= div_quo;
		if (cmd.out_load) begin
			est_vx <= x_q[0];
			est_vy <= x_q[1];
			est_ax <= x_q[2];
			est_ay <= x_q[3];
			accel_magnitude <= root[31] ? 31'h7FFF_FFFF : root[30:0];
		end
	end

	kvaf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (res),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	kvaf_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (acc_q),
		.done   (sqrt_done),
		.root   (root)
	);

	assign sts.det_zero  = (det_q == 32'sd0);
	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;

endmodule

[design/kalman_velocity_accel_filter_top.sv]
// Top level of the four-state velocity/acceleration Kalman filter.
// Usage notes:
//   meas carries one word per operation: init (load vx, vy, ax, ay), predict
//   (constant-acceleration step over step_time), update (measured vx, vy) or
//   the unused code, which only reports. est returns exactly one word per
//   accepted word: the state after the step and |a| = sqrt(ax^2 + ay^2).
//   wr_en/wr_idx/wr_data write step_time, q_velocity, q_accel, r_measure;
//   write only while no word is in flight.
//   One word is processed at a time. Every job runs on the one shared 32x32
//   multiplier. In an update the eight gain divisions, one quotient bit per
//   cycle, dominate. A singular innovation ends the update before the gain
//   divisions start.
//   meas.ready is high whenever the sequencer is idle, so a new word can be
//   taken while the previous result is still held on est. If est stalls, the
//   finished result waits in the sequencer until the output register frees.
//   Reset (arst_n low) clears the state to zero, P to the identity and the
//   registers to their default values; no result is pending afterwards.
module kalman_velocity_accel_filter_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	kvaf_in_if.sink            meas,
	kvaf_out_if.source         est,
	input  logic               wr_en,
	input  logic [1:0]         wr_idx,
	input  logic [16:0]        wr_data
);
	kvaf_pkg::cmd_t cmd;
	kvaf_pkg::sts_t sts;

	// sequencer: owns both handshakes and the job schedule
	kvaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (meas.valid),
		.in_op     (meas.op),
		.in_ready  (meas.ready),
		.out_valid (est.valid),
		.out_ready (est.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: state, covariance, arithmetic units and result register
	kvaf_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.wr_en           (wr_en),
		.wr_idx          (wr_idx),
		.wr_data         (wr_data),
		.in_vx           (meas.vel_x),
		.in_vy           (meas.vel_y),
		.in_ax           (meas.acc_x),
		.in_ay           (meas.acc_y),
		.est_vx          (est.est_vx),
		.est_vy          (est.est_vy),
		.est_ax          (est.est_ax),
		.est_ay          (est.est_ay),
		.accel_magnitude (est.accel_magnitude)
	);

endmodule
